FILE: src/sacl_pkg.sv
// Shared constants and types for the set-associative LFU cache lookup block.
`default_nettype none
package sacl_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int OFFSET_W   = 5;
  localparam int INDEX_W    = 4;
  localparam int WAYS_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = 5'd6;
  localparam logic [INDEX_W-1:0]  INDEX_RST  = 4'd7;
  localparam logic [WAYS_W-1:0]   WAYS_RST   = 4'd1;

  // result fields
  localparam int TOTAL_W   = 32;
  localparam int WAY_OUT_W = 3;

  // back-end status seen by the top level
  typedef struct packed {
    logic clearing;  // reset sweep over the tag store in progress
    logic load;      // output register loaded this cycle
  } sacl_stat_t;

endpackage
`default_nettype wire

FILE: src/sacl_front.sv
// Front end: takes an address beat, splits it into set index and tag, stages it.
`default_nettype none
module sacl_front
  import sacl_pkg::*;
#(
  parameter int ADDRESS_BITS = 48,
  parameter int SET_BITS     = 10,
  parameter int IDX_W        = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [OFFSET_W-1:0]     offset_bits,
  input  wire logic [INDEX_W-1:0]      index_bits,
  input  wire logic                    clearing,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [ADDRESS_BITS-1:0] in_access_address,
  output logic                         q_valid,
  input  wire logic                    q_ready,
  output logic [IDX_W-1:0]             q_set,
  output logic [ADDRESS_BITS-1:0]      q_tag
);

  logic                    fv_r, fv_nxt;
  logic [IDX_W-1:0]        set_r;
  logic [ADDRESS_BITS-1:0] tag_r;
  logic [INDEX_W-1:0]      ib_u;
  logic [ADDRESS_BITS-1:0] above, mask;

  // clamp index field to what the set store holds
  always_comb begin
    if (32'(index_bits) > SET_BITS) ib_u = INDEX_W'(SET_BITS);
    else                            ib_u = index_bits;
    above = in_access_address >> offset_bits;
    mask  = ~({ADDRESS_BITS{1'b1}} << ib_u);
  end

  assign in_ready = !clearing && (!fv_r || q_ready);
  assign q_valid  = fv_r;
  assign q_set    = set_r;
  assign q_tag    = tag_r;

  always_comb begin
    fv_nxt = fv_r;
    if (q_ready) fv_nxt = 1'b0;
    if (in_valid && in_ready) fv_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  // payload stage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      set_r <= IDX_W'(above & mask);
      tag_r <= above >> ib_u;
    end
  end

endmodule
`default_nettype wire

FILE: src/sacl_queue.sv
// Two-entry queue between front and back ends.
`default_nettype none
module sacl_queue #(
  parameter int WIDTH = 58
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

FILE: src/sacl_back.sv
// Back end: set store, hit search, LFU victim pick, update, totals, result register.
`default_nettype none
module sacl_back
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS     = 8,
  parameter int ADDRESS_BITS = 48,
  parameter int COUNT_BITS   = 16,
  parameter int SET_BITS     = 10,
  parameter int IDX_W        = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [WAYS_W-1:0]       ways_in_use,
  input  wire logic                    q_valid,
  output logic                         q_ready,
  input  wire logic [IDX_W-1:0]        q_set,
  input  wire logic [ADDRESS_BITS-1:0] q_tag,
  output sacl_stat_t                   stat,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_was_hit,
  output logic [WAY_OUT_W-1:0]         out_way_used,
  output logic [TOTAL_W-1:0]           out_hits_so_far,
  output logic [TOTAL_W-1:0]           out_misses_so_far
);

  localparam int DEPTH   = 1 << SET_BITS;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int TAGS_W  = MAX_WAYS * ADDRESS_BITS;
  localparam int CNTS_W  = MAX_WAYS * COUNT_BITS;
  localparam int CLR_W   = SET_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;

  // set store, one row per set
  logic [MAX_WAYS-1:0] vmem [DEPTH];
  logic [TAGS_W-1:0]   tmem [DEPTH];
  logic [CNTS_W-1:0]   cmem [DEPTH];
  logic [MAX_WAYS-1:0] vrd_r;
  logic [TAGS_W-1:0]   trd_r;
  logic [CNTS_W-1:0]   crd_r;

  logic [IDX_W-1:0]        set_r;
  logic [ADDRESS_BITS-1:0] tag_r;

  logic [TOTAL_W-1:0] hit_tot_r, hit_tot_nxt, miss_tot_r, miss_tot_nxt;
  logic               ov_r, ov_nxt;
  logic               ohit_r;
  logic [WAY_W-1:0]   oway_r;

  logic [WCNT_W-1:0]   ways_u;
  logic                hit, any_inv, load;
  logic [WAY_W-1:0]    hit_way, inv_way, min_way, pick;
  logic [COUNT_BITS-1:0] min_cnt;
  logic [MAX_WAYS-1:0] vwr;
  logic [TAGS_W-1:0]   twr;
  logic [CNTS_W-1:0]   cwr;
  logic                we;
  logic [IDX_W-1:0]    waddr;

  // clamp way count to 1..MAX_WAYS
  always_comb begin
    if (ways_in_use == '0)                ways_u = WCNT_W'(1);
    else if (32'(ways_in_use) > MAX_WAYS) ways_u = WCNT_W'(MAX_WAYS);
    else                                  ways_u = WCNT_W'(ways_in_use);
  end

  // search the row: first hit, first invalid, lowest count
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < 32'(ways_u)) begin
        if (vrd_r[w] && trd_r[w*ADDRESS_BITS +: ADDRESS_BITS] == tag_r) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!vrd_r[w]) begin
          any_inv = 1'b1;
          inv_way = WAY_W'(w);
        end
      end
    end
    min_cnt = crd_r[COUNT_BITS-1:0];
    min_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (w < 32'(ways_u) && crd_r[w*COUNT_BITS +: COUNT_BITS] < min_cnt) begin
        min_cnt = crd_r[w*COUNT_BITS +: COUNT_BITS];
        min_way = WAY_W'(w);
      end
    end
    if (hit)          pick = hit_way;
    else if (any_inv) pick = inv_way;
    else              pick = min_way;
  end

  // merged row to write back
  always_comb begin
    vwr = vrd_r;
    twr = trd_r;
    cwr = crd_r;
    if (hit) begin
      if (crd_r[pick*COUNT_BITS +: COUNT_BITS] != COUNT_MAX)
        cwr[pick*COUNT_BITS +: COUNT_BITS] = crd_r[pick*COUNT_BITS +: COUNT_BITS] + 1'b1;
    end else begin
      vwr[pick] = 1'b1;
      twr[pick*ADDRESS_BITS +: ADDRESS_BITS] = tag_r;
      cwr[pick*COUNT_BITS +: COUNT_BITS] = '0;
    end
  end

  assign load    = (state_r == ST_EVAL) && (!ov_r || out_ready);
  assign q_ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    ov_nxt       = ov_r;
    hit_tot_nxt  = hit_tot_r;
    miss_tot_nxt = miss_tot_r;
    we           = 1'b0;
    waddr        = set_r;
    if (out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = IDX_W'(clr_r[CLR_W-2:0] & {(CLR_W-1){1'b1}});
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == DEPTH - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (load) begin
          we        = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
          if (hit) begin
            if (hit_tot_r != '1) hit_tot_nxt = hit_tot_r + 1'b1;
          end else begin
            if (miss_tot_r != '1) miss_tot_nxt = miss_tot_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      ov_r       <= 1'b0;
      hit_tot_r  <= '0;
      miss_tot_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      ov_r       <= ov_nxt;
      hit_tot_r  <= hit_tot_nxt;
      miss_tot_r <= miss_tot_nxt;
    end
  end

  // accepted entry and result payload
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      set_r <= q_set;
      tag_r <= q_tag;
    end
    if (load) begin
      ohit_r <= hit;
      oway_r <= pick;
    end
  end

  // store: one write port, one registered read port held while the beat is evaluated
  always_ff @(posedge clk) begin
    if (we) begin
      vmem[waddr] <= (state_r == ST_CLEAR) ? '0 : vwr;
      tmem[waddr] <= (state_r == ST_CLEAR) ? '0 : twr;
      cmem[waddr] <= (state_r == ST_CLEAR) ? '0 : cwr;
    end
    if (q_valid && q_ready) begin
      vrd_r <= vmem[q_set];
      trd_r <= tmem[q_set];
      crd_r <= cmem[q_set];
    end
  end

  assign stat.clearing     = (state_r == ST_CLEAR);
  assign stat.load         = load;
  assign out_valid         = ov_r;
  assign out_was_hit       = ohit_r;
  assign out_way_used      = WAY_OUT_W'(oway_r);
  assign out_hits_so_far   = hit_tot_r;
  assign out_misses_so_far = miss_tot_r;

endmodule
`default_nettype wire

FILE: src/set_assoc_cache_lfu_lookup_core.sv
// Top level of the set-associative cache tag lookup with LFU replacement.
//
//  channel | ports                                        | dir | handshake
//  --------+----------------------------------------------+-----+-----------------
//  in      | in_access_address                            | in  | in_valid/in_ready
//  out     | out_was_hit, out_way_used, out_hits_so_far,  | out | out_valid/out_ready
//          | out_misses_so_far                            |     |
//  cfg     | cfg_index, cfg_wdata                         | in  | cfg_we, no wait
//
// In the back end each access beat is handled in order: the registered read of
// the set row, then the hit/victim search and the row write-back. Front stage
// and a 2-entry queue let a new beat be taken while the back end works.
// After reset a sweep clears the set store, one set per cycle, over all 2^SET_BITS
// sets (1024 by default), with in_ready low; cfg writes are taken throughout.
// A held result in the output register stalls only the back end's final step.
`default_nettype none
module set_assoc_cache_lfu_lookup_core
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS     = 8,
  parameter int MAX_SETS     = 1024,
  parameter int ADDRESS_BITS = 48,
  parameter int COUNT_BITS   = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [ADDRESS_BITS-1:0] in_access_address,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_was_hit,
  output logic [WAY_OUT_W-1:0]         out_way_used,
  output logic [TOTAL_W-1:0]           out_hits_so_far,
  output logic [TOTAL_W-1:0]           out_misses_so_far
);

  // largest index field whose set count fits in MAX_SETS
  localparam int SET_BITS = $clog2(MAX_SETS + 1) - 1;
  localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int QW       = IDX_W + ADDRESS_BITS;

  logic [OFFSET_W-1:0] offset_r;
  logic [INDEX_W-1:0]  index_r;
  logic [WAYS_W-1:0]   ways_r;

  sacl_stat_t              stat;
  logic                    f_valid, f_ready, b_valid, b_ready;
  logic [IDX_W-1:0]        f_set;
  logic [ADDRESS_BITS-1:0] f_tag;
  logic [QW-1:0]           b_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      index_r  <= INDEX_RST;
      ways_r   <= WAYS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_r <= cfg_wdata[OFFSET_W-1:0];
        REG_INDEX_BITS:  index_r  <= cfg_wdata[INDEX_W-1:0];
        REG_WAYS_IN_USE: ways_r   <= cfg_wdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  sacl_front #(
    .ADDRESS_BITS(ADDRESS_BITS), .SET_BITS(SET_BITS), .IDX_W(IDX_W)
  ) u_front (
    .clk, .rst_n,
    .offset_bits(offset_r), .index_bits(index_r), .clearing(stat.clearing),
    .in_valid, .in_ready, .in_access_address,
    .q_valid(f_valid), .q_ready(f_ready), .q_set(f_set), .q_tag(f_tag)
  );

  sacl_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data({f_set, f_tag}),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  sacl_back #(
    .MAX_WAYS(MAX_WAYS), .ADDRESS_BITS(ADDRESS_BITS), .COUNT_BITS(COUNT_BITS),
    .SET_BITS(SET_BITS), .IDX_W(IDX_W)
  ) u_back (
    .clk, .rst_n,
    .ways_in_use(ways_r),
    .q_valid(b_valid), .q_ready(b_ready),
    .q_set(b_data[QW-1:ADDRESS_BITS]), .q_tag(b_data[ADDRESS_BITS-1:0]),
    .stat,
    .out_valid, .out_ready, .out_was_hit, .out_way_used,
    .out_hits_so_far, .out_misses_so_far
  );

  // no beat is taken while the store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_ready) else $error("input taken during clear sweep");

  // a loaded result is presented next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    stat.load |=> out_valid) else $error("loaded result not presented");

  // every result follows at least one counted access
  a_totals_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hits_so_far != '0 || out_misses_so_far != '0))
    else $error("result with zero totals");

  // a hit result carries a nonzero hit total
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_hit |-> out_hits_so_far != '0)
    else $error("hit not counted");

endmodule
`default_nettype wire
